[sv/dcgf_pkg.sv]
// ----------------------------------------------------------------------------
// dcgf_pkg
// Shared types and constants of the dual counter glitch filter with history.
// ----------------------------------------------------------------------------
package dcgf_pkg;

  localparam int unsigned HISTORY_DEPTH_DEF = 10;
  localparam int unsigned COUNT_WIDTH_DEF   = 32;
  localparam int unsigned TIME_WIDTH_DEF    = 48;

  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned INTERVAL_W  = 16;
  localparam int unsigned MAX_JUMP_W  = 32;
  localparam int unsigned FILLED_W    = 4;

  localparam logic [INTERVAL_W-1:0] MIN_INTERVAL_RST   = 16'd5;
  localparam logic [MAX_JUMP_W-1:0] MAX_JUMP_RST       = 32'd1000;
  localparam logic [INTERVAL_W-1:0] STORE_INTERVAL_RST = 16'd200;
  localparam logic [INTERVAL_W-1:0] MIN_AGE_RST        = 16'd1280;

  localparam logic [FILLED_W-1:0] FILLED_MAX = 4'd15;

  typedef enum logic [1:0] {
    CFG_MIN_INTERVAL,
    CFG_MAX_JUMP,
    CFG_STORE_INTERVAL,
    CFG_MIN_AGE
  } cfg_idx_e;

endpackage

[sv/dcgf_chk.sv]
// ----------------------------------------------------------------------------
// dcgf_chk
// Glitch check of one counter against its last good value.
// ----------------------------------------------------------------------------
module dcgf_chk #(
  parameter int unsigned COUNT_WIDTH = dcgf_pkg::COUNT_WIDTH_DEF
) (
  input  logic [COUNT_WIDTH-1:0]          val_i,
  input  logic [COUNT_WIDTH-1:0]          last_i,
  input  logic [dcgf_pkg::MAX_JUMP_W-1:0] max_jump_i,
  input  logic                            have_prev_i,
  output logic                            bad_o,
  output logic [COUNT_WIDTH-1:0]          val_o
);
  import dcgf_pkg::*;

  localparam int unsigned XW = (COUNT_WIDTH > MAX_JUMP_W) ? COUNT_WIDTH : MAX_JUMP_W;

  logic [COUNT_WIDTH-1:0] diff;
  logic                   backwards;
  logic                   jump;

  assign diff      = val_i - last_i;
  assign backwards = val_i < last_i;
  assign jump      = XW'(diff) > XW'(max_jump_i);
  assign bad_o     = have_prev_i & (backwards | jump);
  assign val_o     = bad_o ? last_i : val_i;

endmodule

[sv/dcgf_slot.sv]
// ----------------------------------------------------------------------------
// dcgf_slot
// One history slot; loads the values on its inputs (the new poll or its neighbor's contents) when enabled.
// ----------------------------------------------------------------------------
module dcgf_slot #(
  parameter int unsigned COUNT_WIDTH = dcgf_pkg::COUNT_WIDTH_DEF,
  parameter int unsigned TIME_WIDTH  = dcgf_pkg::TIME_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic [COUNT_WIDTH-1:0] a_i,
  input  logic [COUNT_WIDTH-1:0] b_i,
  input  logic [TIME_WIDTH-1:0]  time_i,
  output logic [COUNT_WIDTH-1:0] a_o,
  output logic [COUNT_WIDTH-1:0] b_o,
  output logic [TIME_WIDTH-1:0]  time_o
);
  import dcgf_pkg::*;

  logic [COUNT_WIDTH-1:0] a_q;
  logic [COUNT_WIDTH-1:0] b_q;
  logic [TIME_WIDTH-1:0]  time_q;

  // time of zero marks an empty slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q <= '0;
    end else if (en_i) begin
      time_q <= time_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end
  end

  assign a_o    = a_q;
  assign b_o    = b_q;
  assign time_o = time_q;

endmodule

[sv/dual_counter_glitch_filter_history_top.sv]
// ----------------------------------------------------------------------------
// dual_counter_glitch_filter_history_top
// Poll filter for two counters with a shifting history of stored polls.
// ----------------------------------------------------------------------------
// One poll request is taken every clock cycle and its result appears in the
// output register in the next cycle. The whole state update (interval check,
// both glitch checks, history shift and oldest-slot check) happens in the
// cycle the request is taken, so a poll may follow in the next cycle; the
// only source of back pressure is the output register held by out_stall_i.
module dual_counter_glitch_filter_history_top #(
  parameter int unsigned HISTORY_DEPTH = dcgf_pkg::HISTORY_DEPTH_DEF,
  parameter int unsigned COUNT_WIDTH   = dcgf_pkg::COUNT_WIDTH_DEF,
  parameter int unsigned TIME_WIDTH    = dcgf_pkg::TIME_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  dcgf_pkg::cfg_idx_e              cfg_idx_i,
  input  logic [dcgf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [TIME_WIDTH-1:0]           time_ms_i,
  input  logic                            read_ok_i,
  input  logic [COUNT_WIDTH-1:0]          count_a_i,
  input  logic [COUNT_WIDTH-1:0]          count_b_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            accepted_o,
  output logic                            bad_a_o,
  output logic                            bad_b_o,
  output logic [COUNT_WIDTH-1:0]          good_a_o,
  output logic [COUNT_WIDTH-1:0]          good_b_o,
  output logic [TIME_WIDTH-1:0]           recent_time_o,
  output logic [dcgf_pkg::FILLED_W-1:0]   filled_slots_o,
  output logic                            oldest_valid_o,
  output logic [COUNT_WIDTH-1:0]          oldest_a_o,
  output logic [COUNT_WIDTH-1:0]          oldest_b_o,
  output logic [TIME_WIDTH-1:0]           oldest_time_o
);
  import dcgf_pkg::*;

  localparam int unsigned CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(HISTORY_DEPTH);

  // configuration
  logic [INTERVAL_W-1:0] min_interval_q;
  logic [MAX_JUMP_W-1:0] max_jump_q;
  logic [INTERVAL_W-1:0] store_interval_q;
  logic [INTERVAL_W-1:0] min_age_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_interval_q   <= MIN_INTERVAL_RST;
      max_jump_q       <= MAX_JUMP_RST;
      store_interval_q <= STORE_INTERVAL_RST;
      min_age_q        <= MIN_AGE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MIN_INTERVAL:   min_interval_q   <= cfg_data_i[INTERVAL_W-1:0];
        CFG_MAX_JUMP:       max_jump_q       <= cfg_data_i[MAX_JUMP_W-1:0];
        CFG_STORE_INTERVAL: store_interval_q <= cfg_data_i[INTERVAL_W-1:0];
        CFG_MIN_AGE:        min_age_q        <= cfg_data_i[INTERVAL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // poll state
  logic [TIME_WIDTH-1:0]  latest_q, latest_d;
  logic                   have_prev_q;
  logic [COUNT_WIDTH-1:0] last_a_q, last_b_q;
  logic [CNT_W-1:0]       slot_cnt_q, slot_cnt_d;

  logic out_valid_q;
  logic in_req;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_req     = in_valid_i & ~in_stall_o;

  // interval check against the last accepted poll
  logic [TIME_WIDTH:0] since_last;
  logic                acc;

  assign since_last = {1'b0, time_ms_i} - {1'b0, latest_q};
  assign acc = in_req & read_ok_i & ~since_last[TIME_WIDTH]
             & (since_last[TIME_WIDTH-1:0] >= TIME_WIDTH'(min_interval_q));

  // glitch checks
  logic                   bad_a, bad_b;
  logic [COUNT_WIDTH-1:0] filt_a, filt_b;

  dcgf_chk #(.COUNT_WIDTH(COUNT_WIDTH)) u_chk_a (
    .val_i      (count_a_i),
    .last_i     (last_a_q),
    .max_jump_i (max_jump_q),
    .have_prev_i(have_prev_q),
    .bad_o      (bad_a),
    .val_o      (filt_a)
  );

  dcgf_chk #(.COUNT_WIDTH(COUNT_WIDTH)) u_chk_b (
    .val_i      (count_b_i),
    .last_i     (last_b_q),
    .max_jump_i (max_jump_q),
    .have_prev_i(have_prev_q),
    .bad_o      (bad_b),
    .val_o      (filt_b)
  );

  // history chain
  logic [COUNT_WIDTH-1:0] slot_a [HISTORY_DEPTH];
  logic [COUNT_WIDTH-1:0] slot_b [HISTORY_DEPTH];
  logic [TIME_WIDTH-1:0]  slot_t [HISTORY_DEPTH];

  logic                empty0;
  logic [TIME_WIDTH:0] since_store;
  logic                store_due;
  logic                wr0;
  logic                shift;

  assign empty0      = slot_t[0] == '0;
  assign since_store = {1'b0, time_ms_i} - {1'b0, slot_t[0]};
  assign store_due   = ~since_store[TIME_WIDTH]
                     & (since_store[TIME_WIDTH-1:0] >= TIME_WIDTH'(store_interval_q));
  assign wr0   = acc & (empty0 | store_due);
  assign shift = acc & ~empty0 & store_due;

  dcgf_slot #(.COUNT_WIDTH(COUNT_WIDTH), .TIME_WIDTH(TIME_WIDTH)) u_slot0 (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (wr0),
    .a_i   (filt_a),
    .b_i   (filt_b),
    .time_i(time_ms_i),
    .a_o   (slot_a[0]),
    .b_o   (slot_b[0]),
    .time_o(slot_t[0])
  );

  for (genvar i = 1; i < HISTORY_DEPTH; i++) begin : g_slot
    dcgf_slot #(.COUNT_WIDTH(COUNT_WIDTH), .TIME_WIDTH(TIME_WIDTH)) u_slot (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (shift),
      .a_i   (slot_a[i-1]),
      .b_i   (slot_b[i-1]),
      .time_i(slot_t[i-1]),
      .a_o   (slot_a[i]),
      .b_o   (slot_b[i]),
      .time_o(slot_t[i])
    );
  end

  // leading filled slots
  always_comb begin
    slot_cnt_d = slot_cnt_q;
    if (shift) begin
      if (slot_cnt_q != CNT_FULL) begin
        slot_cnt_d = slot_cnt_q + CNT_W'(1);
      end
    end else if (wr0) begin
      slot_cnt_d = (time_ms_i != '0) ? CNT_W'(1) : '0;
    end
  end

  assign latest_d = acc ? time_ms_i : latest_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latest_q    <= '0;
      have_prev_q <= 1'b0;
      last_a_q    <= '0;
      last_b_q    <= '0;
      slot_cnt_q  <= '0;
    end else if (acc) begin
      latest_q    <= latest_d;
      have_prev_q <= 1'b1;
      last_a_q    <= filt_a;
      last_b_q    <= filt_b;
      slot_cnt_q  <= slot_cnt_d;
    end
  end

  // oldest slot after this poll
  logic [COUNT_WIDTH-1:0] old_a_d, old_b_d;
  logic [TIME_WIDTH-1:0]  old_t_d;
  logic [TIME_WIDTH:0]    old_age;
  logic                   old_ok;

  assign old_a_d = shift ? slot_a[HISTORY_DEPTH-2] : slot_a[HISTORY_DEPTH-1];
  assign old_b_d = shift ? slot_b[HISTORY_DEPTH-2] : slot_b[HISTORY_DEPTH-1];
  assign old_t_d = shift ? slot_t[HISTORY_DEPTH-2] : slot_t[HISTORY_DEPTH-1];
  assign old_age = {1'b0, latest_d} - {1'b0, old_t_d};
  assign old_ok  = (old_t_d != '0) & ~old_age[TIME_WIDTH]
                 & (old_age[TIME_WIDTH-1:0] >= TIME_WIDTH'(min_age_q));

  // output register
  logic                   accepted_q, bad_a_q, bad_b_q, oldest_valid_q;
  logic [COUNT_WIDTH-1:0] good_a_q, good_b_q, oldest_a_q, oldest_b_q;
  logic [TIME_WIDTH-1:0]  recent_time_q, oldest_time_q;
  logic [FILLED_W-1:0]    filled_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= in_req | (out_valid_q & out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_req) begin
      accepted_q     <= acc;
      bad_a_q        <= acc & bad_a;
      bad_b_q        <= acc & bad_b;
      good_a_q       <= acc ? filt_a : last_a_q;
      good_b_q       <= acc ? filt_b : last_b_q;
      recent_time_q  <= latest_d;
      filled_q       <= (32'(slot_cnt_d) > 32'(FILLED_MAX)) ? FILLED_MAX
                                                             : FILLED_W'(slot_cnt_d);
      oldest_valid_q <= old_ok;
      oldest_a_q     <= old_ok ? old_a_d : '0;
      oldest_b_q     <= old_ok ? old_b_d : '0;
      oldest_time_q  <= old_ok ? old_t_d : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign accepted_o     = accepted_q;
  assign bad_a_o        = bad_a_q;
  assign bad_b_o        = bad_b_q;
  assign good_a_o       = good_a_q;
  assign good_b_o       = good_b_q;
  assign recent_time_o  = recent_time_q;
  assign filled_slots_o = filled_q;
  assign oldest_valid_o = oldest_valid_q;
  assign oldest_a_o     = oldest_a_q;
  assign oldest_b_o     = oldest_b_q;
  assign oldest_time_o  = oldest_time_q;

`ifndef SYNTHESIS
  a_shift_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shift |=> slot_cnt_q == (($past(slot_cnt_q) == CNT_FULL) ? CNT_FULL
                                                             : $past(slot_cnt_q) + CNT_W'(1)))
    else $error("slot count did not follow history shift");

  a_empty_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (slot_t[0] == '0) |-> (slot_cnt_q == '0))
    else $error("filled slots counted with empty head slot");

  a_oldest_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && oldest_valid_q) |->
      (oldest_time_q != '0 && recent_time_q >= oldest_time_q))
    else $error("oldest slot reported out of order");

  a_bad_needs_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (bad_a_q || bad_b_q)) |-> accepted_q)
    else $error("counter flagged bad on a dropped request");
`endif

endmodule
